// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL of the life grid engine.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define TLGE_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked assertion, checked in every cycle including reset.
`define TLGE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: hdl/tlge_pkg.sv
// Shared types and constants for the toroidal life grid engine.
// No dependencies.
package tlge_pkg;

  localparam int ROWS_DEF = 64;
  localparam int COLS_DEF = 64;

  localparam logic [3:0] KEEP_COUNT  = 4'd2;
  localparam logic [3:0] BIRTH_COUNT = 4'd3;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_STEP  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef struct packed {
    logic up;
    logic mid;
    logic dn;
  } win_t;

endpackage

// File: hdl/tlge_cell.sv
// One column cell of the generation chain: a three-row vertical window and the life rule.
// Depends on tlge_pkg.
module tlge_cell import tlge_pkg::*; (
  input  logic clk,
  input  logic shift,
  input  logic din,
  input  win_t lwin,
  input  win_t rwin,
  output win_t win,
  output logic nxt
);

  logic [3:0] count;

  always_ff @(posedge clk) begin
    if (shift) begin
      win.up  <= win.mid;
      win.mid <= win.dn;
      win.dn  <= din;
    end
  end

  always_comb begin
    count = 4'(lwin.up) + 4'(lwin.mid) + 4'(lwin.dn)
          + 4'(rwin.up) + 4'(rwin.mid) + 4'(rwin.dn)
          + 4'(win.up) + 4'(win.dn);
    nxt = (count == BIRTH_COUNT) || (win.mid && (count == KEEP_COUNT));
  end

endmodule

// File: hdl/tlge_mem.sv
// Grid row store: one write port, one read port with registered read data.
// Depends on tlge_pkg.
module tlge_mem import tlge_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF,
  localparam int RW = $clog2(ROWS)
) (
  input  logic            clk,
  input  logic            we,
  input  logic [RW-1:0]   waddr,
  input  logic [COLS-1:0] wdata,
  input  logic [RW-1:0]   raddr,
  output logic [COLS-1:0] rdata
);

  logic [COLS-1:0] mem [ROWS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/toroidal_life_grid_engine.sv
// Toroidal life grid engine, top level. Depends on tlge_pkg, tlge_mem, tlge_cell, assert_macros.svh.
// Request flow: a cell write or read passes through S_CELL to S_DONE, a gated request
// goes straight to S_DONE, and clear and step sweep every row through the single memory
// port pair first. A new request is taken only in S_IDLE, once the last result has been
// raised; a stalled result holds the engine.
// Reset: synchronous; a clearing pass over every row follows, in_stall high.
`include "assert_macros.svh"
module toroidal_life_grid_engine import tlge_pkg::*; #(
  parameter int ROWS = ROWS_DEF,
  parameter int COLS = COLS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  input  logic [5:0] row,
  input  logic [5:0] col,
  input  logic       value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       cell_value,
  output logic       applied
);

  localparam int RW = $clog2(ROWS);
  localparam int CW = $clog2(COLS);
  localparam int KW = $clog2(ROWS + 4);

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_CELL  = 6'b000100,
    S_STEP  = 6'b001000,
    S_CLEAR = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t          state;
  logic [KW-1:0]   cnt;
  logic            running;
  logic [1:0]      act_q;
  logic [RW-1:0]   row_q;
  logic [CW-1:0]   col_q;
  logic            value_q;
  logic            res_cell;
  logic            res_applied;
  logic [COLS-1:0] first_row;

  logic            in_take;
  logic            in_range;
  logic            mem_we;
  logic [RW-1:0]   mem_waddr;
  logic [COLS-1:0] mem_wdata;
  logic [RW-1:0]   mem_raddr;
  logic [COLS-1:0] rd_data;
  logic [COLS-1:0] mod_row;
  logic [COLS-1:0] next_row;
  logic [COLS-1:0] win_din;
  logic            win_shift;
  win_t            wins [COLS];

  assign in_stall = (state != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign in_range = (32'(row) < ROWS) && (32'(col) < COLS);

  tlge_mem #(.ROWS(ROWS), .COLS(COLS)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (rd_data)
  );

  for (genvar c = 0; c < COLS; c++) begin : g_cell
    localparam int LF = (c + COLS - 1) % COLS;
    localparam int RT = (c + 1) % COLS;
    tlge_cell u_cell (
      .clk  (clk),
      .shift(win_shift),
      .din  (win_din[c]),
      .lwin (wins[LF]),
      .rwin (wins[RT]),
      .win  (wins[c]),
      .nxt  (next_row[c])
    );
  end

  assign win_din   = (cnt == KW'(ROWS + 2)) ? first_row : rd_data;
  assign win_shift = (state == S_STEP) && (cnt >= KW'(1)) && (cnt <= KW'(ROWS + 2));

  always_comb begin
    mod_row        = rd_data;
    mod_row[col_q] = value_q;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = row_q;
    mem_wdata = mod_row;
    mem_raddr = RW'(row);
    unique case (state)
      S_INIT, S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = RW'(cnt);
        mem_wdata = '0;
      end
      S_CELL: begin
        mem_we = (act_q == ACT_WRITE);
      end
      S_STEP: begin
        mem_we    = (cnt >= KW'(4));
        mem_waddr = RW'(cnt - KW'(4));
        mem_wdata = next_row;
        mem_raddr = (cnt == '0) ? RW'(ROWS - 1) : RW'(cnt - KW'(1));
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      act_q   <= action;
      row_q   <= RW'(row);
      col_q   <= CW'(col);
      value_q <= value;
    end
    if ((state == S_STEP) && (cnt == KW'(2))) begin
      first_row <= rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      cnt         <= '0;
      running     <= 1'b0;
      res_cell    <= 1'b0;
      res_applied <= 1'b0;
    end else begin
      if (cfg_we) begin
        running <= cfg_wdata;
      end
      unique case (state)
        S_INIT: begin
          cnt <= cnt + KW'(1);
          if (cnt == KW'(ROWS - 1)) begin
            cnt   <= '0;
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_take) begin
            res_cell    <= 1'b0;
            res_applied <= 1'b0;
            cnt         <= '0;
            state       <= S_DONE;
            unique case (action) inside
              ACT_WRITE, ACT_READ: begin
                if (in_range) begin
                  state <= S_CELL;
                end
              end
              ACT_STEP: begin
                if (running) begin
                  state <= S_STEP;
                end
              end
              ACT_CLEAR: begin
                if (!running) begin
                  state <= S_CLEAR;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_CELL: begin
          res_cell    <= (act_q == ACT_READ) && rd_data[col_q];
          res_applied <= 1'b1;
          state       <= S_DONE;
        end
        S_STEP: begin
          cnt <= cnt + KW'(1);
          if (cnt == KW'(ROWS + 3)) begin
            res_applied <= 1'b1;
            state       <= S_DONE;
          end
        end
        S_CLEAR: begin
          cnt <= cnt + KW'(1);
          if (cnt == KW'(ROWS - 1)) begin
            res_applied <= 1'b1;
            state       <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_INIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if ((state == S_DONE) && (!out_valid || !out_stall)) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && (!out_valid || !out_stall)) begin
      cell_value <= res_cell;
      applied    <= res_applied;
    end
  end

  `TLGE_ASSERT(a_rise_from_done, clk, rst,
    $rose(out_valid) |-> $past(state) == S_DONE, "result raised outside the done state")
  `TLGE_ASSERT(a_gated_step, clk, rst,
    (in_take && (action == ACT_STEP) && !running) |=> ((state == S_DONE) && !res_applied),
    "gated step did not finish at once")
  `TLGE_ASSERT(a_read_applied, clk, rst,
    (out_valid && cell_value) |-> applied, "cell value set on a request that did not apply")

endmodule

// File: test/testbench.sv
// Self-checking bench for toroidal_life_grid_engine: queued cell writes, reads, steps and
// clears checked against a grid model kept here. Depends on tlge_pkg and the engine RTL.
module testbench;
  import tlge_pkg::*;

  localparam int ROWS = ROWS_DEF;
  localparam int COLS = COLS_DEF;
  localparam int ITEM_TARGET = 1750;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int QUIET_FIRST = 800;
  localparam int QUIET_LAST = 1100;

  typedef struct {
    action_t act;
    logic [5:0] row;
    logic [5:0] col;
    logic value;
  } request_t;

  typedef struct {
    action_t act;
    logic cell_value;
    logic applied;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic cfg_wdata = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = 2'd0;
  logic [5:0] row = 6'd0;
  logic [5:0] col = 6'd0;
  logic value = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic cell_value;
  logic applied;

  logic [COLS-1:0] life_grid [ROWS];
  logic grid_running = 1'b0;
  request_t pending_requests[$];
  outcome_t awaited_results[$];
  request_t current_req;
  outcome_t head;
  int queued_count = 0;
  int accepted_count = 0;
  int results_seen = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int focus_row = 0;
  int focus_col = 0;
  bit send_gap;

  toroidal_life_grid_engine dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action(action),
    .row(row),
    .col(col),
    .value(value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cell_value(cell_value),
    .applied(applied)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic void advance_generation();
    logic [COLS-1:0] nxt [ROWS];
    int up, dn, lf, rt, n;
    for (int r = 0; r < ROWS; r++) begin
      up = (r + ROWS - 1) % ROWS;
      dn = (r + 1) % ROWS;
      for (int c = 0; c < COLS; c++) begin
        lf = (c + COLS - 1) % COLS;
        rt = (c + 1) % COLS;
        n = 0;
        n += life_grid[up][lf] + life_grid[up][c] + life_grid[up][rt];
        n += life_grid[r][lf] + life_grid[r][rt];
        n += life_grid[dn][lf] + life_grid[dn][c] + life_grid[dn][rt];
        if (life_grid[r][c])
          nxt[r][c] = (n == KEEP_COUNT) || (n == BIRTH_COUNT);
        else
          nxt[r][c] = (n == BIRTH_COUNT);
      end
    end
    for (int r = 0; r < ROWS; r++) life_grid[r] = nxt[r];
  endfunction

  function automatic outcome_t apply_to_grid(request_t req);
    outcome_t o;
    bit in_range;
    o.act = req.act;
    o.cell_value = 1'b0;
    o.applied = 1'b0;
    in_range = (int'(req.row) < ROWS) && (int'(req.col) < COLS);
    case (req.act)
      ACT_WRITE: begin
        if (in_range) begin
          life_grid[req.row][req.col] = req.value;
          o.applied = 1'b1;
        end
      end
      ACT_READ: begin
        if (in_range) begin
          o.cell_value = life_grid[req.row][req.col];
          o.applied = 1'b1;
        end
      end
      ACT_STEP: begin
        if (grid_running) begin
          advance_generation();
          o.applied = 1'b1;
        end
      end
      default: begin
        if (!grid_running) begin
          for (int r = 0; r < ROWS; r++) life_grid[r] = '0;
          o.applied = 1'b1;
        end
      end
    endcase
    return o;
  endfunction

  task automatic record_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  task automatic queue_request(input action_t act, input int r, input int c, input logic v);
    request_t req;
    req.act = act;
    req.row = r[5:0];
    req.col = c[5:0];
    req.value = v;
    pending_requests.push_back(req);
    queued_count++;
  endtask

  task automatic queue_noise();
    queue_request(action_t'($urandom_range(3)), $urandom_range(63), $urandom_range(63),
                  1'($urandom_range(1)));
  endtask

  task automatic queue_near(input action_t act);
    queue_request(act, (focus_row + ROWS - 6 + $urandom_range(12)) % ROWS,
                  (focus_col + COLS - 6 + $urandom_range(12)) % COLS, 1'($urandom_range(1)));
  endtask

  task automatic wait_for_drain();
    while (pending_requests.size() != 0 || in_valid || awaited_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_running(input logic on);
    wait_for_drain();
    repeat (ROWS + 8) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= on;
    grid_running = on;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic build_stopped_phase();
    int top, left, h, w;
    top = ($urandom_range(3) == 0) ? $urandom_range(58, 63) : $urandom_range(63);
    left = ($urandom_range(3) == 0) ? $urandom_range(58, 63) : $urandom_range(63);
    h = $urandom_range(3, 8);
    w = $urandom_range(3, 8);
    if ($urandom_range(2) == 0)
      queue_request(ACT_CLEAR, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
    for (int dr = 0; dr < h; dr++) begin
      for (int dc = 0; dc < w; dc++) begin
        if ($urandom_range(9) < 7)
          queue_request(ACT_WRITE, (top + dr) % ROWS, (left + dc) % COLS,
                        $urandom_range(99) < 45);
        if ($urandom_range(19) == 0) queue_noise();
      end
    end
    focus_row = (top + h / 2) % ROWS;
    focus_col = (left + w / 2) % COLS;
    repeat ($urandom_range(4, 12)) queue_near(ACT_READ);
  endtask

  task automatic build_running_phase();
    repeat ($urandom_range(3, 10)) begin
      queue_request(ACT_STEP, $urandom_range(63), $urandom_range(63), 1'($urandom_range(1)));
      repeat ($urandom_range(2, 8)) queue_near(ACT_READ);
      if ($urandom_range(4) == 0) queue_near(ACT_WRITE);
      if ($urandom_range(7) == 0) queue_noise();
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        awaited_results.push_back(apply_to_grid(current_req));
        accepted_count++;
      end
      if (!in_valid || !in_stall) begin
        send_gap = (accepted_count < QUIET_FIRST || accepted_count >= QUIET_LAST) &&
                   ($urandom_range(99) < 11);
        if (pending_requests.size() != 0 && !send_gap) begin
          current_req = pending_requests.pop_front();
          in_valid <= 1'b1;
          action <= current_req.act;
          row <= current_req.row;
          col <= current_req.col;
          value <= current_req.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          record_mismatch($sformatf(
            "result with no request outstanding: cell_value %0b applied %0b",
            cell_value, applied));
        end else begin
          head = awaited_results.pop_front();
          if (cell_value !== head.cell_value)
            record_mismatch($sformatf("%s cell_value expected %0b got %0b",
                                      head.act.name(), head.cell_value, cell_value));
          if (applied !== head.applied)
            record_mismatch($sformatf("%s applied expected %0b got %0b",
                                      head.act.name(), head.applied, applied));
        end
      end
      out_stall <= (results_seen < QUIET_FIRST || results_seen >= QUIET_LAST) &&
                   ($urandom_range(99) < 11);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    for (int r = 0; r < ROWS; r++) life_grid[r] = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    set_running(1'b0);

    queue_request(ACT_READ, 5, 9, 1'b0);
    queue_request(ACT_WRITE, 0, 0, 1'b1);
    queue_request(ACT_WRITE, 63, 63, 1'b1);
    queue_request(ACT_WRITE, 0, 63, 1'b1);
    queue_request(ACT_WRITE, 63, 0, 1'b1);
    queue_request(ACT_READ, 63, 63, 1'b0);
    queue_request(ACT_READ, 0, 63, 1'b1);
    queue_request(ACT_STEP, 63, 63, 1'b1);
    queue_request(ACT_CLEAR, 0, 0, 1'b0);
    queue_request(ACT_READ, 0, 0, 1'b0);
    queue_request(ACT_WRITE, 63, 63, 1'b1);
    queue_request(ACT_WRITE, 0, 63, 1'b1);
    queue_request(ACT_WRITE, 1, 63, 1'b1);
    queue_request(ACT_WRITE, 2, 5, 1'b1);
    queue_request(ACT_WRITE, 2, 5, 1'b0);
    queue_request(ACT_READ, 2, 5, 1'b1);

    set_running(1'b1);
    queue_request(ACT_STEP, 0, 0, 1'b0);
    queue_request(ACT_READ, 0, 62, 1'b0);
    queue_request(ACT_READ, 0, 0, 1'b0);
    queue_request(ACT_READ, 63, 63, 1'b0);
    queue_request(ACT_CLEAR, 63, 63, 1'b1);
    queue_request(ACT_READ, 0, 62, 1'b0);
    queue_request(ACT_WRITE, 40, 21, 1'b1);
    queue_request(ACT_READ, 40, 21, 1'b0);

    while (queued_count < ITEM_TARGET) begin
      set_running(($urandom_range(4) != 0) ? !grid_running : grid_running);
      if (grid_running) build_running_phase();
      else build_stopped_phase();
    end

    wait_for_drain();
    repeat (ROWS + 8) @(posedge clk);
    if (awaited_results.size() != 0)
      record_mismatch($sformatf("%0d requests never produced a result", awaited_results.size()));
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule

// File: toroidal_life_grid_engine.f
+incdir+hdl
hdl/tlge_pkg.sv
hdl/tlge_cell.sv
hdl/tlge_mem.sv
hdl/toroidal_life_grid_engine.sv
test/testbench.sv
